// ===== hdl/sapq_pkg.sv =====
// Shared constants and types for the sorted array priority queue.
`timescale 1ns / 1ps

package sapq_pkg;

    localparam int CAPACITY_DEF  = 128;
    localparam int TAG_BITS_DEF  = 32;
    localparam int PRIO_BITS_DEF = 16;

    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 8;

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_PEEK   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic rem;
    } sapq_cmd_t;

endpackage

// ===== hdl/sapq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts toward or away from the head.
`timescale 1ns / 1ps

module sapq_cell
    import sapq_pkg::*;
#(
    parameter int TAG_BITS  = TAG_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
)
(
    input  logic                        clk,
    input  sapq_cmd_t                   cmd,
    input  logic signed [PRIO_BITS-1:0] new_prio,
    input  logic        [TAG_BITS-1:0]  new_tag,
    input  logic                        occupied,
    input  logic                        prev_ge,
    input  logic signed [PRIO_BITS-1:0] prev_prio,
    input  logic        [TAG_BITS-1:0]  prev_tag,
    input  logic signed [PRIO_BITS-1:0] next_prio,
    input  logic        [TAG_BITS-1:0]  next_tag,
    output logic signed [PRIO_BITS-1:0] prio,
    output logic        [TAG_BITS-1:0]  tag,
    output logic                        ge
);

    logic signed [PRIO_BITS-1:0] prio_reg;
    logic signed [PRIO_BITS-1:0] prio_next;
    logic        [TAG_BITS-1:0]  tag_reg;
    logic        [TAG_BITS-1:0]  tag_next;

    // The new entry settles below every stored entry of equal or higher priority.
    assign ge = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (cmd.ins && !ge)
        begin
            if (prev_ge)
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
            else
            begin
                prio_next = prev_prio;
                tag_next  = prev_tag;
            end
        end
        else if (cmd.rem)
        begin
            prio_next = next_prio;
            tag_next  = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign prio = prio_reg;
    assign tag  = tag_reg;

endmodule

// ===== hdl/sorted_array_priority_queue.sv =====
// Latency: the result of an operation is presented in the cycle after its transfer.
// Throughput: one operation per cycle while the response output is not stalled; every
// cell compares and shifts in parallel, so the whole chain moves together on each insert or remove.
// Reset clears the entry count and the output valid; slot contents are not cleared
// and only occupied slots are ever reported.
`timescale 1ns / 1ps

module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic        [KIND_BITS-1:0]   kind,
    input  logic signed [PRIO_BITS-1:0]   priority_req,
    input  logic        [TAG_BITS-1:0]    entry_tag,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic        [STATUS_BITS-1:0] status,
    output logic signed [PRIO_BITS-1:0]   head_priority,
    output logic        [TAG_BITS-1:0]    head_tag,
    output logic        [COUNT_BITS-1:0]  entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic        [STATUS_BITS-1:0] status_reg;
    logic        [STATUS_BITS-1:0] status_next;
    logic signed [PRIO_BITS-1:0]   head_prio_reg;
    logic signed [PRIO_BITS-1:0]   head_prio_next;
    logic        [TAG_BITS-1:0]    head_tag_reg;
    logic        [TAG_BITS-1:0]    head_tag_next;
    logic        [COUNT_BITS-1:0]  entry_count_reg;
    logic        [COUNT_BITS-1:0]  entry_count_next;
    logic        [CNT_W+COUNT_BITS-1:0] count_ext;

    logic      req_xfer;
    logic      is_full;
    logic      is_empty;
    sapq_cmd_t cmd;

    logic signed [PRIO_BITS-1:0] cell_prio [CAPACITY];
    logic        [TAG_BITS-1:0]  cell_tag  [CAPACITY];
    logic                        cell_ge   [CAPACITY];

    // A new request can enter whenever the output register is empty or draining.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_xfer  = req_valid && !req_stall;
    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        cmd            = '{ins: 1'b0, rem: 1'b0};
        count_next     = count_reg;
        status_next    = ST_OK;
        head_prio_next = '0;
        head_tag_next  = '0;
        unique case (kind)
            KIND_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.ins    = req_xfer;
                    count_next = count_reg + CNT_ONE;
                end
            end
            KIND_REMOVE, KIND_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_prio_next = cell_prio[0];
                    head_tag_next  = cell_tag[0];
                    if (kind == KIND_REMOVE)
                    begin
                        cmd.rem    = req_xfer;
                        count_next = count_reg - CNT_ONE;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        count_ext        = {{COUNT_BITS{1'b0}}, count_next};
        entry_count_next = count_ext[COUNT_BITS-1:0];
    end

    assign rsp_valid_next = req_xfer || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_xfer)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            status_reg      <= status_next;
            head_prio_reg   <= head_prio_next;
            head_tag_reg    <= head_tag_next;
            entry_count_reg <= entry_count_next;
        end
    end

    // Cell 0 is the head; priorities fall toward the tail of the chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                        prev_ge;
        logic signed [PRIO_BITS-1:0] prev_prio;
        logic        [TAG_BITS-1:0]  prev_tag;
        logic signed [PRIO_BITS-1:0] next_prio;
        logic        [TAG_BITS-1:0]  next_tag;

        if (i == 0)
        begin : g_first
            assign prev_ge   = 1'b1;
            assign prev_prio = priority_req;
            assign prev_tag  = entry_tag;
        end
        else
        begin : g_mid
            assign prev_ge   = cell_ge[i-1];
            assign prev_prio = cell_prio[i-1];
            assign prev_tag  = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_prio = cell_prio[i];
            assign next_tag  = cell_tag[i];
        end
        else
        begin : g_inner
            assign next_prio = cell_prio[i+1];
            assign next_tag  = cell_tag[i+1];
        end

        sapq_cell #(
            .TAG_BITS  (TAG_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .new_prio  (priority_req),
            .new_tag   (entry_tag),
            .occupied  (CNT_W'(i) < count_reg),
            .prev_ge   (prev_ge),
            .prev_prio (prev_prio),
            .prev_tag  (prev_tag),
            .next_prio (next_prio),
            .next_tag  (next_tag),
            .prio      (cell_prio[i]),
            .tag       (cell_tag[i]),
            .ge        (cell_ge[i])
        );
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign head_priority = head_prio_reg;
    assign head_tag      = head_tag_reg;
    assign entry_count   = entry_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count exceeds capacity");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> rsp_valid_reg)
        else $error("no result after a request transfer");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && kind == KIND_INSERT && is_full |=>
            status_reg == ST_FULL && $stable(count_reg))
        else $error("insert into a full queue was not rejected");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && kind == KIND_REMOVE && !is_empty |=>
            count_reg == $past(count_reg) - CNT_ONE)
        else $error("remove did not decrement the entry count");
`endif

endmodule
